// File: hw/rtl/atcfp_pkg.sv
// Shared types, character constants and result codes for the command field parser.
// No dependencies.
package atcfp_pkg;

	localparam int CNT_W          = 4;
	localparam int VAL_W          = 16;
	localparam int DEF_MAX_FIELDS = 15;
	localparam int DEF_MAX_NAME   = 15;
	localparam int QDEPTH         = 2;
	localparam int QPTR_W         = $clog2(QDEPTH);
	localparam int QCNT_W         = $clog2(QDEPTH + 1);

	localparam logic [7:0] CHR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHR_EQUAL   = 8'h3D;
	localparam logic [7:0] CHR_COMMA   = 8'h2C;
	localparam logic [7:0] CHR_ZERO    = 8'h30;
	localparam logic [7:0] CHR_NINE    = 8'h39;

	localparam logic [2:0] CLS_NEWLINE = 3'd0;
	localparam logic [2:0] CLS_EQUAL   = 3'd1;
	localparam logic [2:0] CLS_COMMA   = 3'd2;
	localparam logic [2:0] CLS_DIGIT   = 3'd3;
	localparam logic [2:0] CLS_OTHER   = 3'd4;

	localparam logic [1:0] KIND_NAME   = 2'd0;
	localparam logic [1:0] KIND_FIELD  = 2'd1;
	localparam logic [1:0] KIND_NOARGS = 2'd2;

	typedef struct packed {
		logic [2:0] cls;
		logic [7:0] chr;
		logic [3:0] dig;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       name_char;
		logic [CNT_W-1:0] name_pos;
		logic [VAL_W-1:0] field_value;
		logic [CNT_W-1:0] field_pos;
		logic             field_bad;
		logic             line_bad;
		logic [CNT_W-1:0] field_total;
		logic             overflow;
		logic             last;
	} res_t;

endpackage

// File: hw/rtl/atcfp_if.sv
// Request channels of the command field parser: input bytes and result records.
// Depends on nothing but plain logic widths.
interface atcfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;

	modport source (output valid, output line_byte, input ready);
	modport sink (input valid, input line_byte, output ready);
endinterface

interface atcfp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  name_char;
	logic [3:0]  name_pos;
	logic [15:0] field_value;
	logic [3:0]  field_pos;
	logic        field_bad;
	logic        line_bad;
	logic [3:0]  field_total;
	logic        overflow;
	logic        last;

	modport source (output valid, output kind, output name_char, output name_pos,
		output field_value, output field_pos, output field_bad, output line_bad,
		output field_total, output overflow, output last, input ready);
	modport sink (input valid, input kind, input name_char, input name_pos,
		input field_value, input field_pos, input field_bad, input line_bad,
		input field_total, input overflow, input last, output ready);
endinterface

// File: hw/rtl/atcfp_front.sv
// Front end: accepts line bytes and registers them with their character class.
// Depends on atcfp_pkg and atcfp_if.
module atcfp_front (
	input  logic           clk,
	input  logic           arst_n,
	atcfp_in_if.sink       cmd,
	output atcfp_pkg::cmd_t push_data,
	output logic           push_valid,
	input  logic           push_ready
);
	import atcfp_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cls_c;

	assign cmd.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = cmd_s1;

	always_comb begin
		cls_c.chr = cmd.line_byte;
		cls_c.dig = cmd.line_byte[3:0];
		if (cmd.line_byte == CHR_NEWLINE) begin
			cls_c.cls = CLS_NEWLINE;
		end else if (cmd.line_byte == CHR_EQUAL) begin
			cls_c.cls = CLS_EQUAL;
		end else if (cmd.line_byte == CHR_COMMA) begin
			cls_c.cls = CLS_COMMA;
		end else if (cmd.line_byte >= CHR_ZERO && cmd.line_byte <= CHR_NINE) begin
			cls_c.cls = CLS_DIGIT;
		end else begin
			cls_c.cls = CLS_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cls_c;
		end
	end

endmodule

// File: hw/rtl/atcfp_queue.sv
// Short FIFO between the classifying front end and the executing back end.
// Depends on atcfp_pkg.
module atcfp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  atcfp_pkg::cmd_t push_data,
	input  logic            push_valid,
	output logic            push_ready,
	output atcfp_pkg::cmd_t pop_data,
	output logic            pop_valid,
	input  logic            pop_ready
);
	import atcfp_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = cnt_q != QCNT_W'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// depth is a power of two, pointers wrap naturally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/atcfp_back.sv
// Back end: line state, field accumulation and the registered result stage.
// Depends on atcfp_pkg and atcfp_if.
module atcfp_back #(
	parameter int MAX_FIELDS = atcfp_pkg::DEF_MAX_FIELDS,
	parameter int MAX_NAME   = atcfp_pkg::DEF_MAX_NAME
) (
	input  logic            clk,
	input  logic            arst_n,
	input  atcfp_pkg::cmd_t pop_data,
	input  logic            pop_valid,
	output logic            pop_ready,
	atcfp_out_if.source     res
);
	import atcfp_pkg::*;

	logic             in_args_q;
	logic [CNT_W-1:0] name_count_q;
	logic [VAL_W-1:0] acc_q;
	logic             cur_bad_q;
	logic             any_bad_q;
	logic [CNT_W-1:0] field_count_q;
	logic             ovf_q;
	logic             res_valid_q;
	res_t             res_q;

	logic             emit_c;
	res_t             res_c;
	logic             clear_c;
	logic             in_args_c;
	logic [CNT_W-1:0] name_count_c;
	logic [VAL_W-1:0] acc_c;
	logic             cur_bad_c;
	logic             any_bad_c;
	logic [CNT_W-1:0] field_count_c;
	logic             ovf_c;
	logic             name_room;
	logic             field_room;
	logic             pop;

	assign pop_ready  = !res_valid_q || res.ready;
	assign pop        = pop_valid && pop_ready;
	assign name_room  = name_count_q < CNT_W'(MAX_NAME);
	assign field_room = field_count_q < CNT_W'(MAX_FIELDS);

	always_comb begin
		emit_c        = 1'b0;
		clear_c       = 1'b0;
		res_c         = '0;
		res_c.overflow = ovf_q;
		in_args_c     = in_args_q;
		name_count_c  = name_count_q;
		acc_c         = acc_q;
		cur_bad_c     = cur_bad_q;
		any_bad_c     = any_bad_q;
		field_count_c = field_count_q;
		ovf_c         = ovf_q;
		if (!in_args_q) begin
			case (pop_data.cls)
				CLS_NEWLINE: begin
					emit_c     = 1'b1;
					clear_c    = 1'b1;
					res_c.kind = KIND_NOARGS;
					res_c.last = 1'b1;
				end
				CLS_EQUAL: begin
					in_args_c = 1'b1;
				end
				default: begin
					if (name_room) begin
						emit_c          = 1'b1;
						res_c.kind      = KIND_NAME;
						res_c.name_char = pop_data.chr;
						res_c.name_pos  = name_count_q;
						name_count_c    = name_count_q + 1'b1;
					end else begin
						ovf_c = 1'b1;
					end
				end
			endcase
		end else begin
			case (pop_data.cls)
				CLS_DIGIT: begin
					acc_c = (acc_q << 3) + (acc_q << 1) + VAL_W'(pop_data.dig);
				end
				CLS_COMMA: begin
					if (field_room) begin
						emit_c            = 1'b1;
						res_c.kind        = KIND_FIELD;
						res_c.field_value = acc_q;
						res_c.field_pos   = field_count_q;
						res_c.field_bad   = cur_bad_q;
						res_c.line_bad    = any_bad_q;
						field_count_c     = field_count_q + 1'b1;
					end else begin
						ovf_c = 1'b1;
					end
					acc_c     = '0;
					cur_bad_c = 1'b0;
				end
				CLS_NEWLINE: begin
					emit_c         = 1'b1;
					clear_c        = 1'b1;
					res_c.kind     = KIND_FIELD;
					res_c.line_bad = any_bad_q;
					res_c.last     = 1'b1;
					if (field_room) begin
						res_c.field_value = acc_q;
						res_c.field_pos   = field_count_q;
						res_c.field_bad   = cur_bad_q;
						res_c.field_total = field_count_q + 1'b1;
					end else begin
						res_c.field_total = CNT_W'(MAX_FIELDS);
						res_c.overflow    = 1'b1;
					end
				end
				default: begin
					cur_bad_c = 1'b1;
					any_bad_c = 1'b1;
					acc_c     = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_args_q     <= 1'b0;
			name_count_q  <= '0;
			acc_q         <= '0;
			cur_bad_q     <= 1'b0;
			any_bad_q     <= 1'b0;
			field_count_q <= '0;
			ovf_q         <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				res_valid_q <= emit_c;
				if (clear_c) begin
					in_args_q     <= 1'b0;
					name_count_q  <= '0;
					acc_q         <= '0;
					cur_bad_q     <= 1'b0;
					any_bad_q     <= 1'b0;
					field_count_q <= '0;
					ovf_q         <= 1'b0;
				end else begin
					in_args_q     <= in_args_c;
					name_count_q  <= name_count_c;
					acc_q         <= acc_c;
					cur_bad_q     <= cur_bad_c;
					any_bad_q     <= any_bad_c;
					field_count_q <= field_count_c;
					ovf_q         <= ovf_c;
				end
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit_c) begin
			res_q <= res_c;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.kind        = res_q.kind;
	assign res.name_char   = res_q.name_char;
	assign res.name_pos    = res_q.name_pos;
	assign res.field_value = res_q.field_value;
	assign res.field_pos   = res_q.field_pos;
	assign res.field_bad   = res_q.field_bad;
	assign res.line_bad    = res_q.line_bad;
	assign res.field_total = res_q.field_total;
	assign res.overflow    = res_q.overflow;
	assign res.last        = res_q.last;

endmodule

// File: hw/rtl/at_command_field_parser_core.sv
// Command line field parser: one byte per clock in, name characters and
// decimal fields out. The core sustains one byte per clock with no gaps while
// the result side keeps ready high; a result passes the front classify register,
// the two-entry queue and the result register. Bytes before '=' come out as
// name characters, comma- or newline-ended fields as 16-bit values with bad
// and overflow flags; a newline with no '=' gives a no-arguments record.
// No reset sweep; the core is ready right after reset.
// Depends on atcfp_pkg, atcfp_if, atcfp_front, atcfp_queue, atcfp_back.
module at_command_field_parser_core #(
	parameter int MAX_FIELDS = atcfp_pkg::DEF_MAX_FIELDS,
	parameter int MAX_NAME   = atcfp_pkg::DEF_MAX_NAME
) (
	input logic         clk,
	input logic         arst_n,
	atcfp_in_if.sink    cmd,
	atcfp_out_if.source res
);
	import atcfp_pkg::*;

	cmd_t push_data;
	logic push_valid;
	logic push_ready;
	cmd_t pop_data;
	logic pop_valid;
	logic pop_ready;

	atcfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	atcfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	atcfp_back #(
		.MAX_FIELDS (MAX_FIELDS),
		.MAX_NAME   (MAX_NAME)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.res        (res)
	);

endmodule

// File: verif/atcfp_tb_pkg.sv
// Scoreboard for the command field parser regression: a byte-level line parser
// that predicts result records, plus the in-order record checker.
// Depends on atcfp_pkg (res_t, character constants, kind codes, bounds).
`timescale 1ns / 1ps
package atcfp_tb_pkg;
	import atcfp_pkg::*;

	class parse_scoreboard;
		res_t        parsed_records[$];
		int unsigned mismatches;
		logic        in_args;
		logic [3:0]  name_count;
		logic [15:0] acc;
		logic        cur_bad;
		logic        any_bad;
		logic [3:0]  field_count;
		logic        ovf;

		function new();
			mismatches = 0;
			clear_line();
		endfunction

		function void clear_line();
			in_args     = 1'b0;
			name_count  = '0;
			acc         = '0;
			cur_bad     = 1'b0;
			any_bad     = 1'b0;
			field_count = '0;
			ovf         = 1'b0;
		endfunction

		function int pending();
			return parsed_records.size();
		endfunction

		task report(string what, logic [15:0] got_v, logic [15:0] exp_v);
			mismatches++;
			$display("[%0t] parser mismatch %s: got 0x%0h, expected 0x%0h",
				$time, what, got_v, exp_v);
		endtask

		// accepted input byte: advance the line state, queue any record it yields
		function void note_byte(logic [7:0] b);
			res_t r;
			r = '0;
			if (!in_args) begin
				if (b == CHR_NEWLINE) begin
					r.kind     = KIND_NOARGS;
					r.overflow = ovf;
					r.last     = 1'b1;
					parsed_records.push_back(r);
					clear_line();
				end else if (b == CHR_EQUAL) begin
					in_args = 1'b1;
				end else if (name_count < DEF_MAX_NAME) begin
					r.kind      = KIND_NAME;
					r.name_char = b;
					r.name_pos  = name_count;
					r.overflow  = ovf;
					parsed_records.push_back(r);
					name_count++;
				end else begin
					ovf = 1'b1;
				end
			end else if (b >= CHR_ZERO && b <= CHR_NINE) begin
				acc = 16'(acc * 10 + (b - CHR_ZERO));
			end else if (b == CHR_COMMA) begin
				if (field_count < DEF_MAX_FIELDS) begin
					r.kind        = KIND_FIELD;
					r.field_value = acc;
					r.field_pos   = field_count;
					r.field_bad   = cur_bad;
					r.line_bad    = any_bad;
					r.overflow    = ovf;
					parsed_records.push_back(r);
					field_count++;
				end else begin
					ovf = 1'b1;
				end
				acc     = '0;
				cur_bad = 1'b0;
			end else if (b == CHR_NEWLINE) begin
				r.kind     = KIND_FIELD;
				r.line_bad = any_bad;
				r.last     = 1'b1;
				if (field_count < DEF_MAX_FIELDS) begin
					r.field_value = acc;
					r.field_pos   = field_count;
					r.field_bad   = cur_bad;
					r.field_total = field_count + 4'd1;
					r.overflow    = ovf;
				end else begin
					r.field_total = 4'(DEF_MAX_FIELDS);
					r.overflow    = 1'b1;
				end
				parsed_records.push_back(r);
				clear_line();
			end else begin
				cur_bad = 1'b1;
				any_bad = 1'b1;
				acc     = '0;
			end
		endfunction

		task check_record(res_t got);
			res_t exp;
			if (parsed_records.size() == 0) begin
				report("unexpected record, kind", 16'(got.kind), '0);
				return;
			end
			exp = parsed_records.pop_front();
			if (got.kind !== exp.kind)
				report("kind", 16'(got.kind), 16'(exp.kind));
			if (got.name_char !== exp.name_char)
				report("name_char", 16'(got.name_char), 16'(exp.name_char));
			if (got.name_pos !== exp.name_pos)
				report("name_pos", 16'(got.name_pos), 16'(exp.name_pos));
			if (got.field_value !== exp.field_value)
				report("field_value", got.field_value, exp.field_value);
			if (got.field_pos !== exp.field_pos)
				report("field_pos", 16'(got.field_pos), 16'(exp.field_pos));
			if (got.field_bad !== exp.field_bad)
				report("field_bad", 16'(got.field_bad), 16'(exp.field_bad));
			if (got.line_bad !== exp.line_bad)
				report("line_bad", 16'(got.line_bad), 16'(exp.line_bad));
			if (got.field_total !== exp.field_total)
				report("field_total", 16'(got.field_total), 16'(exp.field_total));
			if (got.overflow !== exp.overflow)
				report("overflow", 16'(got.overflow), 16'(exp.overflow));
			if (got.last !== exp.last)
				report("last", 16'(got.last), 16'(exp.last));
		endtask
	endclass

endpackage

// File: verif/tb_top.sv
// Regression top for at_command_field_parser_core: directed and random command
// lines in, every result record checked in order against the scoreboard.
// Depends on atcfp_pkg, atcfp_if, atcfp_tb_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
	import atcfp_pkg::*;
	import atcfp_tb_pkg::*;

	logic clk;
	logic arst_n;

	atcfp_in_if  cmd_if();
	atcfp_out_if res_if();

	at_command_field_parser_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	parse_scoreboard ledger;
	res_t            seen;
	int              bytes_in;
	bit              tx_idle;
	bit              rx_idle;
	logic            stall_rx;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (cmd_if.valid && cmd_if.ready) begin
			ledger.note_byte(cmd_if.line_byte);
			bytes_in <= bytes_in + 1;
		end
		if (res_if.valid && res_if.ready) begin
			seen.kind        = res_if.kind;
			seen.name_char   = res_if.name_char;
			seen.name_pos    = res_if.name_pos;
			seen.field_value = res_if.field_value;
			seen.field_pos   = res_if.field_pos;
			seen.field_bad   = res_if.field_bad;
			seen.line_bad    = res_if.line_bad;
			seen.field_total = res_if.field_total;
			seen.overflow    = res_if.overflow;
			seen.last        = res_if.last;
			ledger.check_record(seen);
		end
	end

	function automatic logic [7:0] digit_char();
		return CHR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] bad_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while ((c >= CHR_ZERO && c <= CHR_NINE) || c == CHR_COMMA || c == CHR_NEWLINE);
		return c;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid     <= 1'b1;
		cmd_if.line_byte <= b;
		do
			@(posedge clk);
		while (!cmd_if.ready);
	endtask

	// receiver: per-result random hold-off, long stall on request
	initial begin
		int gap;
		int taken;
		taken = 0;
		rx_idle = 1'b1;
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (stall_rx) begin
				res_if.ready <= 1'b0;
				while (stall_rx) @(posedge clk);
			end
			gap = rx_idle ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!res_if.valid && !stall_rx);
			taken++;
			if (taken % 40 == 0)
				rx_idle = ($urandom_range(0, 2) != 0);
		end
	end

	// long receiver hold-off so the core backs up onto its input
	initial begin
		stall_rx <= 1'b0;
		while (bytes_in < 400) @(posedge clk);
		stall_rx <= 1'b1;
		repeat (120) @(posedge clk);
		stall_rx <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("at_command_field_parser_core regression: fail");
		$finish;
	end

	initial begin
		logic [7:0] opening[$];
		logic [7:0] line_q[$];
		logic [7:0] c;
		int         sent;
		int         nlen;
		int         nfld;
		int         ndig;
		bit         paused;

		ledger   = new();
		sent     = 0;
		paused   = 1'b0;
		tx_idle  = 1'b1;
		arst_n           <= 1'b0;
		cmd_if.valid     <= 1'b0;
		cmd_if.line_byte <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty line, byte extremes as name, empty field, modular wrap,
		// bad byte then digit, second '=', full 16-bit value
		opening = {CHR_NEWLINE, 8'h00, 8'hFF, CHR_NEWLINE, CHR_EQUAL, CHR_COMMA,
			"9", "9", "9", "9", "9", CHR_COMMA, "x", "7", CHR_EQUAL, "3", CHR_COMMA,
			CHR_NEWLINE, CHR_EQUAL, "6", "5", "5", "3", "5", CHR_NEWLINE};
		foreach (opening[i]) send_byte(opening[i]);
		sent = opening.size();

		while (sent < 1950) begin
			line_q.delete();
			tx_idle = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 12)) begin
					case ($urandom_range(0, 4))
						0: c = CHR_NEWLINE;
						1: c = CHR_EQUAL;
						2: c = CHR_COMMA;
						3: c = digit_char();
						default: c = 8'($urandom_range(0, 255));
					endcase
					line_q.push_back(c);
				end
			end else begin
				nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20)
					: $urandom_range(0, 6);
				repeat (nlen) begin
					do
						c = 8'($urandom_range(0, 255));
					while (c == CHR_NEWLINE || c == CHR_EQUAL);
					line_q.push_back(c);
				end
				if ($urandom_range(0, 9) != 0) begin
					line_q.push_back(CHR_EQUAL);
					nfld = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18)
						: $urandom_range(1, 5);
					for (int f = 0; f < nfld; f++) begin
						ndig = $urandom_range(0, 6);
						repeat (ndig)
							line_q.push_back(($urandom_range(0, 15) == 0) ? bad_char()
								: digit_char());
						if (f < nfld - 1)
							line_q.push_back(CHR_COMMA);
					end
				end
				line_q.push_back(CHR_NEWLINE);
			end
			foreach (line_q[i]) send_byte(line_q[i]);
			sent += line_q.size();
			if (!paused && sent >= 1000) begin
				paused = 1'b1;
				cmd_if.valid <= 1'b0;
				do
					@(posedge clk);
				while (ledger.pending() != 0);
			end
		end

		cmd_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (ledger.pending() != 0);
		repeat (10) @(posedge clk);
		if (ledger.mismatches == 0)
			$display("at_command_field_parser_core regression: pass");
		else
			$display("at_command_field_parser_core regression: fail");
		$finish;
	end

endmodule
